### src/plst_pkg.sv
package plst_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_DUMP   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e            op;
    logic [CNT_W-1:0]    pos;
    logic [CNT_W-1:0]    cnt;
    logic [DATA_W-1:0]   value;
  } cell_ctrl_t;

endpackage

### src/positional_list_store_unit.sv
// Ordered list of up to 64 signed 32-bit entries held in a chain of cells, one entry per
// cell. Insert and delete shift the whole chain at once and return one item the next
// cycle, so they sustain one item per cycle while the output is not stalled. Dump and
// search rotate the chain one step per cycle through cell 0: a dump of N entries gives N
// items, a search gives one item at the end; the chain is back in order afterwards.
// An empty list answers a dump or search at once. Out-of-range positions and inserts into
// a full list return an error status and leave the list untouched. While a rotation runs,
// new items are stalled; a stall on the output pauses the rotation.
module positional_list_store_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [6:0]                          position_i,
  input  logic signed [31:0]                  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic [5:0]                          index_o,
  output logic signed [31:0]                  element_o,
  output logic [6:0]                          entry_count_o,
  output logic                                last_o
);

  plst_pkg::state_e state_q, state_d;

  logic [plst_pkg::CNT_W-1:0]  count_q, count_d;
  plst_pkg::cmd_e              mode_q, mode_d;
  logic [plst_pkg::DATA_W-1:0] key_q, key_d;
  logic [plst_pkg::IDX_W-1:0]  step_q, step_d;
  logic                        found_q, found_d;
  logic [plst_pkg::IDX_W-1:0]  fidx_q, fidx_d;

  // output register
  logic                        out_valid_q;
  logic [2:0]                  status_q, status_d;
  logic [5:0]                  index_q, index_d;
  logic [31:0]                 element_q, element_d;
  logic [6:0]                  ecount_q, ecount_d;
  logic                        last_q, last_d;
  logic                        load;

  plst_pkg::cell_ctrl_t        ctrl;
  plst_pkg::cmd_e              cmd;
  logic [plst_pkg::DATA_W-1:0] head;
  logic                        out_free;
  logic                        accept;
  logic                        is_last;
  logic                        match;
  logic                        full;

  assign cmd      = plst_pkg::cmd_e'(command_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == plst_pkg::S_IDLE) && out_free);
  assign accept   = in_valid_i && !in_stall_o;
  assign is_last  = ({1'b0, step_q} == (count_q - plst_pkg::CNT_W'(1)));
  assign match    = (head == key_q);
  assign full     = (count_q >= plst_pkg::CNT_W'(plst_pkg::DEPTH));

  plst_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      plst_pkg::S_IDLE: begin
        if (accept && (count_q != '0) &&
            ((cmd == plst_pkg::CMD_DUMP) || (cmd == plst_pkg::CMD_SEARCH))) begin
          state_d = plst_pkg::S_SCAN;
        end
      end
      plst_pkg::S_SCAN: begin
        if (out_free && is_last) begin
          state_d = plst_pkg::S_IDLE;
        end
      end
      default: state_d = plst_pkg::S_IDLE;
    endcase
  end

  // chain control, bookkeeping and result
  always_comb begin
    ctrl.op    = plst_pkg::OP_HOLD;
    ctrl.pos   = position_i;
    ctrl.cnt   = count_q;
    ctrl.value = value_i;
    count_d    = count_q;
    mode_d     = mode_q;
    key_d      = key_q;
    step_d     = step_q;
    found_d    = found_q;
    fidx_d     = fidx_q;
    load       = 1'b0;
    status_d   = plst_pkg::ST_OK;
    index_d    = '0;
    element_d  = '0;
    ecount_d   = count_q;
    last_d     = 1'b1;

    case (state_q)
      plst_pkg::S_IDLE: begin
        if (accept) begin
          mode_d  = cmd;
          key_d   = value_i;
          step_d  = '0;
          found_d = 1'b0;
          case (cmd)
            plst_pkg::CMD_INSERT: begin
              load = 1'b1;
              if (full) begin
                status_d = plst_pkg::ST_FULL;
              end else if (position_i > count_q) begin
                status_d = plst_pkg::ST_BADPOS;
              end else begin
                ctrl.op  = plst_pkg::OP_INS;
                count_d  = count_q + plst_pkg::CNT_W'(1);
                ecount_d = count_d;
              end
            end
            plst_pkg::CMD_DELETE: begin
              load = 1'b1;
              if (position_i >= count_q) begin
                status_d = plst_pkg::ST_BADPOS;
              end else begin
                ctrl.op  = plst_pkg::OP_DEL;
                count_d  = count_q - plst_pkg::CNT_W'(1);
                ecount_d = count_d;
              end
            end
            plst_pkg::CMD_DUMP: begin
              if (count_q == '0) begin
                load     = 1'b1;
                status_d = plst_pkg::ST_EMPTY;
              end
            end
            plst_pkg::CMD_SEARCH: begin
              if (count_q == '0) begin
                load     = 1'b1;
                status_d = plst_pkg::ST_NOTFOUND;
              end
            end
            default: load = 1'b0;
          endcase
        end
      end
      plst_pkg::S_SCAN: begin
        if (out_free) begin
          ctrl.op    = plst_pkg::OP_ROT;
          ctrl.value = head;
          step_d     = step_q + plst_pkg::IDX_W'(1);
          if (mode_q == plst_pkg::CMD_DUMP) begin
            load      = 1'b1;
            index_d   = step_q;
            element_d = head;
            last_d    = is_last;
          end else begin
            if (match && !found_q) begin
              found_d = 1'b1;
              fidx_d  = step_q;
            end
            if (is_last) begin
              load = 1'b1;
              if (found_q) begin
                index_d = fidx_q;
              end else if (match) begin
                index_d = step_q;
              end else begin
                status_d = plst_pkg::ST_NOTFOUND;
              end
            end
          end
        end
      end
      default: ctrl.op = plst_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plst_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    key_q   <= key_d;
    step_q  <= step_d;
    found_q <= found_d;
    fidx_q  <= fidx_d;
    if (load) begin
      status_q  <= status_d;
      index_q   <= index_d;
      element_q <= element_d;
      ecount_q  <= ecount_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign index_o       = index_q;
  assign element_o     = element_q;
  assign entry_count_o = ecount_q;
  assign last_o        = last_q;

  // count never passes the chain length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= plst_pkg::CNT_W'(plst_pkg::DEPTH))
    else $error("entry count above depth");

  // a rotation never changes the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plst_pkg::S_SCAN) |=> $stable(count_q))
    else $error("count changed during scan");

  // a good insert grows the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd == plst_pkg::CMD_INSERT) && !full && (position_i <= count_q))
      |=> (count_q == $past(count_q) + plst_pkg::CNT_W'(1)))
    else $error("insert did not grow the list");

  // a rotation step only happens when the output register can take its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == plst_pkg::OP_ROT) |-> (out_free && (state_q == plst_pkg::S_SCAN)))
    else $error("rotation while output blocked");

endmodule

### src/plst_cell.sv
module plst_cell (
  input  logic                            clk_i,
  input  logic [plst_pkg::IDX_W-1:0]      my_idx_i,
  input  plst_pkg::cell_ctrl_t            ctrl_i,
  input  logic [plst_pkg::DATA_W-1:0]     left_i,
  input  logic [plst_pkg::DATA_W-1:0]     right_i,
  output logic [plst_pkg::DATA_W-1:0]     data_o
);

  logic [plst_pkg::DATA_W-1:0] data_q, data_d;
  logic [plst_pkg::CNT_W-1:0]  idx_ext;
  logic [plst_pkg::CNT_W-1:0]  last_idx;

  assign idx_ext  = {1'b0, my_idx_i};
  assign last_idx = ctrl_i.cnt - plst_pkg::CNT_W'(1);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      plst_pkg::OP_INS: begin
        if (idx_ext > ctrl_i.pos) begin
          data_d = left_i;
        end else if (idx_ext == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      plst_pkg::OP_DEL: begin
        if (idx_ext >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      plst_pkg::OP_ROT: begin
        // value carries the head entry, which wraps to the tail
        if (idx_ext == last_idx) begin
          data_d = ctrl_i.value;
        end else if (idx_ext < last_idx) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### src/plst_chain.sv
module plst_chain (
  input  logic                         clk_i,
  input  plst_pkg::cell_ctrl_t         ctrl_i,
  output logic [plst_pkg::DATA_W-1:0]  head_o
);

  logic [plst_pkg::DATA_W-1:0] data [plst_pkg::DEPTH];

  for (genvar gi = 0; gi < plst_pkg::DEPTH; gi++) begin : g_cell
    logic [plst_pkg::DATA_W-1:0] left, right;

    if (gi == 0) begin : g_first
      assign left = ctrl_i.value;
    end else begin : g_mid_l
      assign left = data[gi-1];
    end

    if (gi == plst_pkg::DEPTH - 1) begin : g_last
      assign right = data[gi];
    end else begin : g_mid_r
      assign right = data[gi+1];
    end

    plst_cell u_cell (
      .clk_i    (clk_i),
      .my_idx_i (plst_pkg::IDX_W'(gi)),
      .ctrl_i   (ctrl_i),
      .left_i   (left),
      .right_i  (right),
      .data_o   (data[gi])
    );
  end

  assign head_o = data[0];

endmodule
